// ===== rtl/segx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_pkg - shared types and constants for segment_intersection
// Fixed output width, queue depth and the queue status bundle.
// ----------------------------------------------------------------------------
package segx_pkg;

  // width of each result coordinate (fixed point, signed)
  localparam int OUT_BITS   = 24;
  // entries in the queue between front and back
  localparam int FIFO_DEPTH = 4;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/segment_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection - exact 2D segment intersection test and point
// Takes two segments per transaction and returns hit plus intersection point.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per segment pair. in_tdata holds, from bit 0 up,
//           a0_x, a0_y, a1_x, a1_y, b0_x, b0_y, b1_x, b1_y, COORD_BITS each.
//   out_* : one transaction per input. out_tdata holds cross_x then cross_y
//           (24 bits each, FRAC_BITS fraction bits); out_tuser[0] is hit.
//   Throughput: one pair per cycle sustained while out_tready is high.
//   Path: the input transaction passes three front stages, the queue
//   register, the load stage, one divide stage per multiplier bit, then the
//   output register.
//   Reset (rst_n low, synchronous) empties all stages and the queue.
//   When out_tready is low the divide pipeline holds; the front keeps taking
//   pairs until the four-entry queue between them fills, then in_tready drops.
// ----------------------------------------------------------------------------
module segment_intersection import segx_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [8*COORD_BITS-1:0] in_tdata,   // a0_x, a0_y, a1_x, a1_y, b0_x, b0_y, b1_x, b1_y
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [2*OUT_BITS-1:0]   out_tdata,  // cross_x, cross_y
  output logic [0:0]              out_tuser   // hit
);

  localparam int DW = 2 * COORD_BITS + 2;
  localparam int PW = 1 + 2 * DW + 2 * (COORD_BITS + 1) + 2 * COORD_BITS;

  logic                fifo_push, fifo_pop;
  logic [PW-1:0]       front_data, fifo_data;
  fifo_stat_t          fifo_st;
  logic                hit;
  logic [OUT_BITS-1:0] cx, cy;

  // classification front
  segx_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .fst      (fifo_st),
    .push     (fifo_push),
    .pdata    (front_data)
  );

  // decoupling queue
  segx_fifo #(.W(PW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .din   (front_data),
    .pop   (fifo_pop),
    .dout  (fifo_data),
    .fst   (fifo_st)
  );

  // point computation back
  segx_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pdata     (fifo_data),
    .fst       (fifo_st),
    .pop       (fifo_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hit   (hit),
    .out_x     (cx),
    .out_y     (cy)
  );

  assign out_tdata = {cy, cx};
  assign out_tuser = hit;

`ifndef ASSERT_OFF
  // input stalls only because the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> fifo_st.full) else $error("input stalled with queue not full");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0)) else $error("miss with nonzero point");

  // full and empty never together
  a_fifo_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_st.full && fifo_st.empty)) else $error("queue full and empty");

  // a pop from an empty queue never happens
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_st.empty) else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/segx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_front - input stage and hit classification
// Three-stage pipeline: edge vectors, cross products, then the exact
// in-range test with sign normalization. Results are pushed to the queue.
// ----------------------------------------------------------------------------
module segx_front import segx_pkg::*; #(
  parameter  int COORD_BITS = 16,
  localparam int DW = 2 * COORD_BITS + 2,
  localparam int PW = 1 + 2 * DW + 2 * (COORD_BITS + 1) + 2 * COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [8*COORD_BITS-1:0] in_data,
  input  fifo_stat_t              fst,
  output logic                    push,
  output logic [PW-1:0]           pdata
);

  localparam int C  = COORD_BITS;
  localparam int PB = 2 * C + 2;
  localparam int EB = 2 * C + 3;

  logic adv;

  // unpacked coordinates
  logic signed [C-1:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;

  // stage 1: edge vectors
  logic                v1_r;
  logic signed [C:0]   s1x_r, s1y_r, s2x_r, s2y_r, wx_r, wy_r;
  logic signed [C-1:0] a0x1_r, a0y1_r;

  // stage 2: cross products
  logic                v2_r;
  logic signed [PB-1:0] pd1_r, pd2_r, ps1_r, ps2_r, pt1_r, pt2_r;
  logic signed [C:0]   s1x2_r, s1y2_r;
  logic signed [C-1:0] a0x2_r, a0y2_r;

  // stage 3: classified item
  logic                v3_r;
  logic                hit_r, hit_nxt;
  logic [DW-1:0]       den_r, den_nxt, tn_r, tn_nxt;
  logic signed [C:0]   s1x3_r, s1y3_r;
  logic signed [C-1:0] a0x3_r, a0y3_r;

  logic signed [EB-1:0] den_c, sn_c, tn_c;
  logic                 neg;

  assign a0x = signed'(in_data[0*C +: C]);
  assign a0y = signed'(in_data[1*C +: C]);
  assign a1x = signed'(in_data[2*C +: C]);
  assign a1y = signed'(in_data[3*C +: C]);
  assign b0x = signed'(in_data[4*C +: C]);
  assign b0y = signed'(in_data[5*C +: C]);
  assign b1x = signed'(in_data[6*C +: C]);
  assign b1y = signed'(in_data[7*C +: C]);

  // pipeline moves unless the last stage holds an item the queue cannot take
  assign adv      = !v3_r || !fst.full;
  assign in_ready = adv;
  assign push     = v3_r && !fst.full;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      s1x_r  <= (C+1)'(a1x) - (C+1)'(a0x);
      s1y_r  <= (C+1)'(a1y) - (C+1)'(a0y);
      s2x_r  <= (C+1)'(b1x) - (C+1)'(b0x);
      s2y_r  <= (C+1)'(b1y) - (C+1)'(b0y);
      wx_r   <= (C+1)'(a0x) - (C+1)'(b0x);
      wy_r   <= (C+1)'(a0y) - (C+1)'(b0y);
      a0x1_r <= a0x;
      a0y1_r <= a0y;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (adv) begin
      pd1_r  <= s1x_r * s2y_r;
      pd2_r  <= s2x_r * s1y_r;
      ps1_r  <= s1x_r * wy_r;
      ps2_r  <= s1y_r * wx_r;
      pt1_r  <= s2x_r * wy_r;
      pt2_r  <= s2y_r * wx_r;
      s1x2_r <= s1x_r;
      s1y2_r <= s1y_r;
      a0x2_r <= a0x1_r;
      a0y2_r <= a0y1_r;
    end
  end

  // stage 3: both parameters in [0,1] against a denominator of known sign
  always_comb begin
    den_c = EB'(pd1_r) - EB'(pd2_r);
    sn_c  = EB'(ps1_r) - EB'(ps2_r);
    tn_c  = EB'(pt1_r) - EB'(pt2_r);
    neg   = den_c[EB-1];
    if (neg) begin
      hit_nxt = (sn_c <= 0) && (sn_c >= den_c) && (tn_c <= 0) && (tn_c >= den_c);
      den_nxt = DW'(-den_c);
      tn_nxt  = DW'(-tn_c);
    end else begin
      hit_nxt = (den_c != 0) && (sn_c >= 0) && (sn_c <= den_c) &&
                (tn_c >= 0) && (tn_c <= den_c);
      den_nxt = DW'(den_c);
      tn_nxt  = DW'(tn_c);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r  <= hit_nxt;
      den_r  <= den_nxt;
      tn_r   <= tn_nxt;
      s1x3_r <= s1x2_r;
      s1y3_r <= s1y2_r;
      a0x3_r <= a0x2_r;
      a0y3_r <= a0y2_r;
    end
  end

  assign pdata = {hit_r, den_r, tn_r, s1x3_r, s1y3_r, a0x3_r, a0y3_r};

endmodule

// ===== rtl/segx_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_fifo - short queue between front and back
// Register-based queue of FIFO_DEPTH entries with full/empty status.
// ----------------------------------------------------------------------------
module segx_fifo import segx_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output fifo_stat_t   fst
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [W-1:0]  mem_r [FIFO_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign fst.full  = (cnt_r == CW'(FIFO_DEPTH));
  assign fst.empty = (cnt_r == '0);
  assign dout      = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

// ===== rtl/segx_dstep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_dstep - one step of the multiply-divide
// Takes one multiplier bit: r = 2r + bit*num, then reduces r below den
// with up to two subtractions, shifting the count into the quotient.
// ----------------------------------------------------------------------------
module segx_dstep #(
  parameter int DW = 34,
  parameter int QW = 25
) (
  input  logic          kbit,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] r_in,
  input  logic [QW-1:0] q_in,
  output logic [DW-1:0] r_out,
  output logic [QW-1:0] q_out
);

  logic [DW+1:0] r2, den1, den2;
  logic          ge1, ge2;

  always_comb begin
    r2   = (DW+2)'({r_in, 1'b0}) + (DW+2)'(kbit ? num : '0);
    den1 = (DW+2)'(den);
    den2 = (DW+2)'({den, 1'b0});
    ge2  = (r2 >= den2);
    ge1  = (r2 >= den1);
    if (ge2) begin
      r_out = DW'(r2 - den2);
      q_out = QW'({q_in, 1'b0}) + QW'(2'd2);
    end else if (ge1) begin
      r_out = DW'(r2 - den1);
      q_out = QW'({q_in, 1'b0}) + QW'(2'd1);
    end else begin
      r_out = DW'(r2);
      q_out = QW'({q_in, 1'b0});
    end
  end

endmodule

// ===== rtl/segx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_back - intersection point computation and output register
// Pipelined bit-serial multiply-divide of tnum*|delta|*2^F by den for x
// and y, then sign handling, truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module segx_back import segx_pkg::*; #(
  parameter  int COORD_BITS = 16,
  parameter  int FRAC_BITS  = 8,
  localparam int DW = 2 * COORD_BITS + 2,
  localparam int PW = 1 + 2 * DW + 2 * (COORD_BITS + 1) + 2 * COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [PW-1:0]         pdata,
  input  fifo_stat_t            fst,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [OUT_BITS-1:0]   out_x,
  output logic [OUT_BITS-1:0]   out_y
);

  localparam int C     = COORD_BITS;
  localparam int KW    = C + FRAC_BITS;
  localparam int NSTEP = KW;
  localparam int QW    = KW + 1;
  localparam int VW    = (C + FRAC_BITS + 3 > OUT_BITS + 1) ? C + FRAC_BITS + 3 : OUT_BITS + 1;
  localparam logic signed [VW-1:0] SAT_HI = VW'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;

  // unpacked queue entry
  logic                in_hit;
  logic [DW-1:0]       in_den, in_tn;
  logic signed [C:0]   in_s1x, in_s1y;
  logic signed [C-1:0] in_a0x, in_a0y;

  logic adv;

  // per-stage pipeline registers
  logic                val_r  [NSTEP+1];
  logic                hit_r  [NSTEP+1];
  logic                nx_r   [NSTEP+1];
  logic                ny_r   [NSTEP+1];
  logic [DW-1:0]       num_r  [NSTEP+1];
  logic [DW-1:0]       den_r  [NSTEP+1];
  logic [KW-1:0]       kx_r   [NSTEP+1];
  logic [KW-1:0]       ky_r   [NSTEP+1];
  logic [DW-1:0]       rx_r   [NSTEP+1];
  logic [DW-1:0]       ry_r   [NSTEP+1];
  logic [QW-1:0]       qx_r   [NSTEP+1];
  logic [QW-1:0]       qy_r   [NSTEP+1];
  logic signed [C-1:0] bx_r   [NSTEP+1];
  logic signed [C-1:0] by_r   [NSTEP+1];

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [OUT_BITS-1:0]   out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  assign {in_hit, in_den, in_tn, in_s1x, in_s1y, in_a0x, in_a0y} = pdata;

  // whole back pipeline moves while the output register can be refilled
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !fst.empty;

  // a0 + q or a0 - q, rounded toward zero, saturated to the output width
  function automatic logic [OUT_BITS-1:0] finish(input logic signed [C-1:0] base,
                                                 input logic neg,
                                                 input logic [QW-1:0] q,
                                                 input logic rnz);
    logic signed [VW-1:0] b;
    logic signed [VW-1:0] qq;
    logic signed [VW-1:0] v;
    b  = VW'(base) <<< FRAC_BITS;
    qq = signed'(VW'(q));
    if (!neg) begin
      v = b + qq;
      if (rnz && (v < 0)) v = v + VW'(1);
    end else begin
      v = b - qq;
      if (rnz && (v > 0)) v = v - VW'(1);
    end
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return OUT_BITS'(v);
  endfunction

  // stage 0: load from queue, split deltas into sign and magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r[0] <= 1'b0;
    end else if (adv) begin
      val_r[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r[0] <= in_hit;
      nx_r[0]  <= in_s1x[C];
      ny_r[0]  <= in_s1y[C];
      num_r[0] <= in_tn;
      den_r[0] <= in_den;
      kx_r[0]  <= KW'(C'(in_s1x[C] ? -in_s1x : in_s1x)) << FRAC_BITS;
      ky_r[0]  <= KW'(C'(in_s1y[C] ? -in_s1y : in_s1y)) << FRAC_BITS;
      rx_r[0]  <= '0;
      ry_r[0]  <= '0;
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      bx_r[0]  <= in_a0x;
      by_r[0]  <= in_a0y;
    end
  end

  // divide stages, one multiplier bit each, most significant first
  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic [DW-1:0] rx_c, ry_c;
    logic [QW-1:0] qx_c, qy_c;

    segx_dstep #(.DW(DW), .QW(QW)) u_dx (
      .kbit  (kx_r[j][KW-1-j]),
      .num   (num_r[j]),
      .den   (den_r[j]),
      .r_in  (rx_r[j]),
      .q_in  (qx_r[j]),
      .r_out (rx_c),
      .q_out (qx_c)
    );

    segx_dstep #(.DW(DW), .QW(QW)) u_dy (
      .kbit  (ky_r[j][KW-1-j]),
      .num   (num_r[j]),
      .den   (den_r[j]),
      .r_in  (ry_r[j]),
      .q_in  (qy_r[j]),
      .r_out (ry_c),
      .q_out (qy_c)
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[j+1] <= 1'b0;
      end else if (adv) begin
        val_r[j+1] <= val_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hit_r[j+1] <= hit_r[j];
        nx_r[j+1]  <= nx_r[j];
        ny_r[j+1]  <= ny_r[j];
        num_r[j+1] <= num_r[j];
        den_r[j+1] <= den_r[j];
        kx_r[j+1]  <= kx_r[j];
        ky_r[j+1]  <= ky_r[j];
        rx_r[j+1]  <= rx_c;
        ry_r[j+1]  <= ry_c;
        qx_r[j+1]  <= qx_c;
        qy_r[j+1]  <= qy_c;
        bx_r[j+1]  <= bx_r[j];
        by_r[j+1]  <= by_r[j];
      end
    end
  end

  // output point, zero on a miss
  always_comb begin
    if (hit_r[NSTEP]) begin
      out_x_nxt = finish(bx_r[NSTEP], nx_r[NSTEP], qx_r[NSTEP], rx_r[NSTEP] != '0);
      out_y_nxt = finish(by_r[NSTEP], ny_r[NSTEP], qy_r[NSTEP], ry_r[NSTEP] != '0);
    end else begin
      out_x_nxt = '0;
      out_y_nxt = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= val_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= hit_r[NSTEP];
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

endmodule
